// ===== rtl/dapm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dapm_pkg
// Shared types, codes and constants of the dispense and pickup monitor.
// ----------------------------------------------------------------------------
package dapm_pkg;

    // Pill counts per compartment.
    localparam int QTY_BITS = 4;

    localparam int ACT_W    = 2;
    localparam int ECHO_W   = 13;
    localparam int DIST_W   = 10;
    localparam int TIMER_W  = 14;
    localparam int SINCE_W  = 20;
    localparam int ABS_W    = 16;

    localparam int HOLD_W   = 14;
    localparam int GAP_W    = 14;
    localparam int COOL_W   = 16;
    localparam int CONF_W   = 16;
    localparam int TOUT_W   = 20;
    localparam int PRES_W   = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_HOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUT_GAP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT   = 3'd5;

    // Register reset values.
    localparam logic [HOLD_W-1:0] RST_OPEN_HOLD = 14'd500;
    localparam logic [GAP_W-1:0]  RST_SHUT_GAP  = 14'd200;
    localparam logic [COOL_W-1:0] RST_COOLDOWN  = 16'd5000;
    localparam logic [CONF_W-1:0] RST_CONFIRM   = 16'd10000;
    localparam logic [TOUT_W-1:0] RST_TIMEOUT   = 20'd180000;
    localparam logic [PRES_W-1:0] RST_PRESENT   = 10'd5;

    // Distance = floor(echo * 17 / 1000), done as echo * DIST_MULT >> DIST_SHIFT.
    // The rounded-up reciprocal is exact for every 13-bit echo value.
    localparam int DIST_SHIFT = 24;
    localparam int DIST_MULT_W = 19;
    localparam logic [DIST_MULT_W-1:0] DIST_MULT = 19'd285213;
    localparam int PROD_W = ECHO_W + DIST_MULT_W;
    localparam int DIST_RAW_W = 8;
    localparam logic [DIST_W-1:0] NO_ECHO_CM = 10'd999;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_OPEN  = 2'd1,
        ACT_CLOSE = 2'd2,
        ACT_DENY  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_DISP = 2'd1,
        MODE_WAIT = 2'd2,
        MODE_LOCK = 2'd3
    } t_mode;

    localparam logic [1:0] OUTC_NONE   = 2'd0;
    localparam logic [1:0] OUTC_TAKEN  = 2'd1;
    localparam logic [1:0] OUTC_MISSED = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [QTY_BITS-1:0] qty_a;
        logic [QTY_BITS-1:0] qty_b;
        logic [ECHO_W-1:0]   echo_us;
    } t_item;

    typedef struct packed {
        logic              lid_a_open;
        logic              lid_b_open;
        logic [1:0]        mode;
        logic [1:0]        outcome;
        logic [DIST_W-1:0] distance_cm;
    } t_result;

    typedef struct packed {
        logic [HOLD_W-1:0] open_hold_ms;
        logic [GAP_W-1:0]  shut_gap_ms;
        logic [COOL_W-1:0] cooldown_ms;
        logic [CONF_W-1:0] confirm_ms;
        logic [TOUT_W-1:0] timeout_ms;
        logic [PRES_W-1:0] present_cm;
    } t_cfg;

endpackage
`default_nettype wire

// ===== rtl/dapm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dapm_in_if
// Input channel: ticks and commands with their payload.
// ----------------------------------------------------------------------------
interface dapm_in_if import dapm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [QTY_BITS-1:0] qty_a;
    logic [QTY_BITS-1:0] qty_b;
    logic [ECHO_W-1:0]   echo_us;

    modport source (output valid, output action, output qty_a, output qty_b,
                    output echo_us, input ready);
    modport sink   (input valid, input action, input qty_a, input qty_b,
                    input echo_us, output ready);
endinterface
`default_nettype wire

// ===== rtl/dapm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dapm_out_if
// Result channel: lid drives, mode, outcome and sampled distance.
// ----------------------------------------------------------------------------
interface dapm_out_if import dapm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              lid_a_open;
    logic              lid_b_open;
    logic [1:0]        mode;
    logic [1:0]        outcome;
    logic [DIST_W-1:0] distance_cm;

    modport source (output valid, output lid_a_open, output lid_b_open, output mode,
                    output outcome, output distance_cm, input ready);
    modport sink   (input valid, input lid_a_open, input lid_b_open, input mode,
                    input outcome, input distance_cm, output ready);
endinterface
`default_nettype wire

// ===== rtl/dispense_and_pickup_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dispense_and_pickup_monitor
// Two-lid pill dispenser sequencer with ultrasonic pickup confirmation.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake      Payload
//  i_in      in         valid/ready    action, qty_a, qty_b, echo_us
//  o_out     out        valid/ready    lid_a_open, lid_b_open, mode, outcome,
//                                      distance_cm
//  i_cfg_*   in         write enable   register index, write data
//
// Each accepted item yields exactly one result. An item is captured in the
// input register, processed once the result register is free, and its
// result is shown from the result register. One item per cycle is sustained
// while the result is not stalled; the figure is set by the single step of
// state-update logic between the two registers. Reset is synchronous, active
// low, and returns all but the payload registers to defaults.
// A stalled result holds the result register; the input register still
// accepts a new item whenever the result register will be free.
// ----------------------------------------------------------------------------
module dispense_and_pickup_monitor import dapm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    dapm_in_if.sink                    i_in,
    dapm_out_if.source                 o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg        cfg;
    t_item       r_in;
    logic        r_in_valid;
    t_result     r_out;
    logic        r_out_valid;
    t_result     step_res;
    logic [DIST_W-1:0] dist_cm;
    logic        step;
    logic        out_free;

    // The result register is free when empty or when its transfer completes.
    assign out_free = !r_out_valid || o_out.ready;
    // The held item is processed when its result has a place to go.
    assign step     = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || step;

    dapm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    dapm_dist u_dist (
        .i_echo_us (r_in.echo_us),
        .o_dist_cm (dist_cm)
    );

    dapm_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .i_dist_cm (dist_cm),
        .o_res     (step_res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.action  <= i_in.action;
            r_in.qty_a   <= i_in.qty_a;
            r_in.qty_b   <= i_in.qty_b;
            r_in.echo_us <= i_in.echo_us;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.lid_a_open  = r_out.lid_a_open;
    assign o_out.lid_b_open  = r_out.lid_b_open;
    assign o_out.mode        = r_out.mode;
    assign o_out.outcome     = r_out.outcome;
    assign o_out.distance_cm = r_out.distance_cm;

endmodule
`default_nettype wire

// ===== rtl/dapm_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dapm_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module dapm_cfg import dapm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_hold_ms <= RST_OPEN_HOLD;
            r_cfg.shut_gap_ms  <= RST_SHUT_GAP;
            r_cfg.cooldown_ms  <= RST_COOLDOWN;
            r_cfg.confirm_ms   <= RST_CONFIRM;
            r_cfg.timeout_ms   <= RST_TIMEOUT;
            r_cfg.present_cm   <= RST_PRESENT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OPEN_HOLD: r_cfg.open_hold_ms <= i_cfg_data[HOLD_W-1:0];
                CFG_SHUT_GAP:  r_cfg.shut_gap_ms  <= i_cfg_data[GAP_W-1:0];
                CFG_COOLDOWN:  r_cfg.cooldown_ms  <= i_cfg_data[COOL_W-1:0];
                CFG_CONFIRM:   r_cfg.confirm_ms   <= i_cfg_data[CONF_W-1:0];
                CFG_TIMEOUT:   r_cfg.timeout_ms   <= i_cfg_data[TOUT_W-1:0];
                CFG_PRESENT:   r_cfg.present_cm   <= i_cfg_data[PRES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ===== rtl/dapm_dist.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dapm_dist
// Converts an echo length in microseconds to a distance in centimeters.
// ----------------------------------------------------------------------------
module dapm_dist import dapm_pkg::*; (
    input  wire logic [ECHO_W-1:0] i_echo_us,
    output logic      [DIST_W-1:0] o_dist_cm
);

    logic [PROD_W-1:0] prod;

    // A single constant multiply by the scaled reciprocal replaces the divide.
    assign prod = PROD_W'(i_echo_us) * PROD_W'(DIST_MULT);

    assign o_dist_cm = (i_echo_us == '0) ? NO_ECHO_CM
                     : DIST_W'(prod[DIST_SHIFT +: DIST_RAW_W]);

endmodule
`default_nettype wire

// ===== rtl/dapm_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dapm_core
// Mode sequencer, lid pulse counters and pickup watch for one item per step.
// ----------------------------------------------------------------------------
module dapm_core import dapm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire t_item             i_item,
    input  wire t_cfg              i_cfg,
    input  wire logic [DIST_W-1:0] i_dist_cm,
    output t_result                o_res
);

    t_mode               r_mode,        n_mode;
    logic [QTY_BITS-1:0] r_left_a,      n_left_a;
    logic [QTY_BITS-1:0] r_left_b,      n_left_b;
    logic                r_lid_phase,   n_lid_phase;
    logic [TIMER_W-1:0]  r_phase_timer, n_phase_timer;
    logic [SINCE_W-1:0]  r_since_open,  n_since_open;
    logic                r_absent_flag, n_absent_flag;
    logic [ABS_W-1:0]    r_absent_time, n_absent_time;

    logic                is_tick;
    logic [TIMER_W-1:0]  timer_inc;
    logic [SINCE_W-1:0]  since_inc;
    logic [QTY_BITS-1:0] dec_a;
    logic [QTY_BITS-1:0] dec_b;
    logic                sample;
    logic                absent_now;
    logic                flag_s;
    logic [ABS_W-1:0]    time_s;
    logic                taken;
    logic                missed;
    logic [1:0]          outcome;
    logic                lids_active;

    assign is_tick   = (t_action'(i_item.action) == ACT_TICK);
    assign timer_inc = (&r_phase_timer) ? r_phase_timer : r_phase_timer + 1'b1;
    assign since_inc = (&r_since_open) ? r_since_open : r_since_open + 1'b1;

    // Lid A empties before lid B starts.
    assign dec_a = (r_left_a != '0) ? r_left_a - 1'b1 : r_left_a;
    assign dec_b = (r_left_a == '0 && r_left_b != '0) ? r_left_b - 1'b1 : r_left_b;

    // Sensor watch, valid on a waiting tick once the cooldown has passed.
    assign sample     = is_tick && (r_mode == MODE_WAIT)
                        && (since_inc >= SINCE_W'(i_cfg.cooldown_ms));
    assign absent_now = (i_dist_cm <= i_cfg.present_cm);
    assign flag_s     = absent_now;
    assign time_s     = !absent_now ? r_absent_time
                      : !r_absent_flag ? '0
                      : (&r_absent_time) ? r_absent_time : r_absent_time + 1'b1;
    assign taken      = flag_s && (time_s >= i_cfg.confirm_ms);
    assign missed     = since_inc >= i_cfg.timeout_ms;
    assign outcome    = !sample ? OUTC_NONE
                      : taken   ? OUTC_TAKEN
                      : missed  ? OUTC_MISSED : OUTC_NONE;

    // Next state.
    always_comb begin
        n_mode        = r_mode;
        n_left_a      = r_left_a;
        n_left_b      = r_left_b;
        n_lid_phase   = r_lid_phase;
        n_phase_timer = r_phase_timer;
        n_since_open  = r_since_open;
        n_absent_flag = r_absent_flag;
        n_absent_time = r_absent_time;
        if (is_tick) begin
            unique case (r_mode)
                MODE_DISP: begin
                    n_phase_timer = timer_inc;
                    if (r_lid_phase) begin
                        if (timer_inc >= i_cfg.open_hold_ms) begin
                            n_lid_phase   = 1'b0;
                            n_phase_timer = '0;
                        end
                    end else if (timer_inc >= i_cfg.shut_gap_ms) begin
                        n_phase_timer = '0;
                        n_left_a      = dec_a;
                        n_left_b      = dec_b;
                        if (dec_a == '0 && dec_b == '0) begin
                            n_mode       = MODE_WAIT;
                            n_since_open = '0;
                        end else begin
                            n_lid_phase = 1'b1;
                        end
                    end
                end
                MODE_WAIT: begin
                    n_since_open = since_inc;
                    if (sample) begin
                        n_absent_flag = flag_s;
                        n_absent_time = time_s;
                        if (outcome != OUTC_NONE) begin
                            n_mode        = MODE_IDLE;
                            n_absent_flag = 1'b0;
                            n_left_a      = '0;
                            n_left_b      = '0;
                            n_lid_phase   = 1'b0;
                            n_phase_timer = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if (r_mode != MODE_DISP) begin
            if (t_action'(i_item.action) == ACT_OPEN) begin
                if (i_item.qty_a != '0 || i_item.qty_b != '0) begin
                    n_mode        = MODE_DISP;
                    n_left_a      = i_item.qty_a;
                    n_left_b      = i_item.qty_b;
                    n_lid_phase   = 1'b1;
                    n_phase_timer = '0;
                    n_since_open  = '0;
                    n_absent_flag = 1'b0;
                    n_absent_time = '0;
                end
            end else begin
                n_left_a      = '0;
                n_left_b      = '0;
                n_lid_phase   = 1'b0;
                n_phase_timer = '0;
                n_mode = (t_action'(i_item.action) == ACT_CLOSE) ? MODE_IDLE : MODE_LOCK;
            end
        end
    end

    // Result of this step, taken from the state after the step.
    always_comb begin
        lids_active       = (n_mode == MODE_DISP) && n_lid_phase;
        o_res.lid_a_open  = lids_active && (n_left_a != '0);
        o_res.lid_b_open  = lids_active && (n_left_a == '0) && (n_left_b != '0);
        o_res.mode        = n_mode;
        o_res.outcome     = outcome;
        o_res.distance_cm = sample ? i_dist_cm : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_IDLE;
            r_left_a      <= '0;
            r_left_b      <= '0;
            r_lid_phase   <= 1'b0;
            r_phase_timer <= '0;
            r_since_open  <= '0;
            r_absent_flag <= 1'b0;
            r_absent_time <= '0;
        end else if (i_step) begin
            r_mode        <= n_mode;
            r_left_a      <= n_left_a;
            r_left_b      <= n_left_b;
            r_lid_phase   <= n_lid_phase;
            r_phase_timer <= n_phase_timer;
            r_since_open  <= n_since_open;
            r_absent_flag <= n_absent_flag;
            r_absent_time <= n_absent_time;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/dapm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dapm_checker
// Port-level checks of the dispense and pickup monitor.
// ----------------------------------------------------------------------------
module dapm_checker import dapm_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic              i_lid_a_open,
    input wire logic              i_lid_b_open,
    input wire logic [1:0]        i_mode,
    input wire logic [1:0]        i_outcome,
    input wire logic [DIST_W-1:0] i_distance_cm
);

    // No result may appear in the cycle after reset.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result keeps its payload.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_lid_a_open, i_lid_b_open, i_mode, i_outcome, i_distance_cm}))
        else $error("stalled result changed");

    // Only one lid is driven open, and only while dispensing.
    a_lid_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_lid_a_open || i_lid_b_open)
            |-> !(i_lid_a_open && i_lid_b_open) && (i_mode == MODE_DISP))
        else $error("lid open outside dispensing or both lids open");

    // A reported outcome returns the block to idle.
    a_outcome_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_outcome != OUTC_NONE) |-> (i_mode == MODE_IDLE))
        else $error("outcome reported without returning to idle");

endmodule

bind dispense_and_pickup_monitor dapm_checker u_dapm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_lid_a_open  (o_out.lid_a_open),
    .i_lid_b_open  (o_out.lid_b_open),
    .i_mode        (o_out.mode),
    .i_outcome     (o_out.outcome),
    .i_distance_cm (o_out.distance_cm)
);
`default_nettype wire

// ===== verif/dapm_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dapm_result_checker
// Watches the command and status channels of the dispense and pickup monitor,
// predicts the status of every accepted command or tick and compares it with
// the status that the block returns.
// ----------------------------------------------------------------------------
module dapm_result_checker import dapm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    dapm_in_if                         i_in,
    dapm_out_if                        i_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_pending,
    output int                         o_fail_count,
    output int                         o_taken_count,
    output int                         o_missed_count
);

    // Predicted copy of the register file and of the sequencer state.
    t_cfg                cfg;
    t_mode               mode_now;
    logic [QTY_BITS-1:0] pills_a;
    logic [QTY_BITS-1:0] pills_b;
    logic                lid_up;
    logic [TIMER_W-1:0]  phase_ms;
    logic [SINCE_W-1:0]  since_done_ms;
    logic                gone_flag;
    logic [ABS_W-1:0]    gone_ms;

    t_result awaited_status[$];

    function automatic void shut_lids();
        pills_a  = '0;
        pills_b  = '0;
        lid_up   = 1'b0;
        phase_ms = '0;
    endfunction

    // Advances the predicted state by one tick or command and returns the status.
    function automatic t_result step_dispenser(input t_item item);
        t_result     res;
        logic [1:0]  outc;
        int unsigned cm;
        logic        lid_active;
        outc = OUTC_NONE;
        cm   = 0;
        if (item.action == ACT_TICK) begin
            if (mode_now == MODE_DISP) begin
                if (phase_ms != '1) phase_ms = phase_ms + 1'b1;
                if (lid_up) begin
                    if (phase_ms >= cfg.open_hold_ms) begin
                        lid_up   = 1'b0;
                        phase_ms = '0;
                    end
                end else if (phase_ms >= cfg.shut_gap_ms) begin
                    phase_ms = '0;
                    if (pills_a != '0) pills_a = pills_a - 1'b1;
                    else if (pills_b != '0) pills_b = pills_b - 1'b1;
                    if (pills_a == '0 && pills_b == '0) begin
                        mode_now      = MODE_WAIT;
                        since_done_ms = '0;
                    end else begin
                        lid_up = 1'b1;
                    end
                end
            end else if (mode_now == MODE_WAIT) begin
                if (since_done_ms != '1) since_done_ms = since_done_ms + 1'b1;
                if (since_done_ms >= cfg.cooldown_ms) begin
                    if (item.echo_us == '0) cm = NO_ECHO_CM;
                    else cm = (32'(item.echo_us) * 17) / 1000;
                    if (cm <= cfg.present_cm) begin
                        if (!gone_flag) begin
                            gone_flag = 1'b1;
                            gone_ms   = '0;
                        end else if (gone_ms != '1) begin
                            gone_ms = gone_ms + 1'b1;
                        end
                    end else begin
                        gone_flag = 1'b0;
                    end
                    if (gone_flag && gone_ms >= cfg.confirm_ms) outc = OUTC_TAKEN;
                    else if (since_done_ms >= cfg.timeout_ms) outc = OUTC_MISSED;
                    if (outc != OUTC_NONE) begin
                        mode_now  = MODE_IDLE;
                        gone_flag = 1'b0;
                        shut_lids();
                    end
                end
            end
        end else if (mode_now != MODE_DISP) begin
            if (item.action == ACT_OPEN) begin
                if (item.qty_a != '0 || item.qty_b != '0) begin
                    mode_now      = MODE_DISP;
                    pills_a       = item.qty_a;
                    pills_b       = item.qty_b;
                    lid_up        = 1'b1;
                    phase_ms      = '0;
                    since_done_ms = '0;
                    gone_flag     = 1'b0;
                    gone_ms       = '0;
                end
            end else begin
                shut_lids();
                if (item.action == ACT_CLOSE) mode_now = MODE_IDLE;
                else mode_now = MODE_LOCK;
            end
        end
        lid_active      = (mode_now == MODE_DISP) && lid_up;
        res.lid_a_open  = lid_active && (pills_a != '0);
        res.lid_b_open  = lid_active && (pills_a == '0) && (pills_b != '0);
        res.mode        = mode_now;
        res.outcome     = outc;
        res.distance_cm = cm[DIST_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_item   item;
        t_result want;
        if (!i_rst_n) begin
            cfg            = '{RST_OPEN_HOLD, RST_SHUT_GAP, RST_COOLDOWN, RST_CONFIRM,
                               RST_TIMEOUT, RST_PRESENT};
            mode_now       = MODE_IDLE;
            shut_lids();
            since_done_ms  = '0;
            gone_flag      = 1'b0;
            gone_ms        = '0;
            awaited_status.delete();
            o_pending      = 0;
            o_fail_count   = 0;
            o_taken_count  = 0;
            o_missed_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OPEN_HOLD: cfg.open_hold_ms = i_cfg_data[HOLD_W-1:0];
                    CFG_SHUT_GAP:  cfg.shut_gap_ms  = i_cfg_data[GAP_W-1:0];
                    CFG_COOLDOWN:  cfg.cooldown_ms  = i_cfg_data[COOL_W-1:0];
                    CFG_CONFIRM:   cfg.confirm_ms   = i_cfg_data[CONF_W-1:0];
                    CFG_TIMEOUT:   cfg.timeout_ms   = i_cfg_data[TOUT_W-1:0];
                    CFG_PRESENT:   cfg.present_cm   = i_cfg_data[PRES_W-1:0];
                    default: ;
                endcase
            end
            // Compare before predicting so that a new item never covers a stray result.
            if (i_out.valid && i_out.ready) begin
                if (awaited_status.size() == 0) begin
                    $error("status transfer with no expectation waiting");
                    o_fail_count++;
                end else begin
                    want = awaited_status.pop_front();
                    check_field("lid_a_open", want.lid_a_open, i_out.lid_a_open);
                    check_field("lid_b_open", want.lid_b_open, i_out.lid_b_open);
                    check_field("mode", want.mode, i_out.mode);
                    check_field("outcome", want.outcome, i_out.outcome);
                    check_field("distance_cm", want.distance_cm, i_out.distance_cm);
                end
            end
            if (i_in.valid && i_in.ready) begin
                item.action  = i_in.action;
                item.qty_a   = i_in.qty_a;
                item.qty_b   = i_in.qty_b;
                item.echo_us = i_in.echo_us;
                want = step_dispenser(item);
                if (want.outcome == OUTC_TAKEN) o_taken_count++;
                if (want.outcome == OUTC_MISSED) o_missed_count++;
                awaited_status.push_back(want);
            end
            o_pending = awaited_status.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the dispense and pickup monitor. A directed opening
// walks the commands and the register extremes, then random dispense cycles
// under many small register settings run with bursty commands and a stalling
// status receiver. The checker beside the block does all of the comparing.
// ----------------------------------------------------------------------------
module tb_top;
    import dapm_pkg::*;

    // Random transfers wanted after the directed opening.
    localparam int RANDOM_ITEMS = 950;
    // Transfers per register setting in the random part.
    localparam int PHASE_ITEMS  = 160;
    // Watchdog bound on the run, many times what the slowest legal run needs.
    localparam int CYCLE_LIMIT  = 400000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int pending;
    int fail_count;
    int taken_count;
    int missed_count;

    int   n_sent;
    int   n_settings;
    int   burst_left;
    int   cycles;
    bit   steady;
    t_cfg cur;

    dapm_in_if  cmd_ch ();
    dapm_out_if status_ch ();

    dispense_and_pickup_monitor u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (cmd_ch),
        .o_out      (status_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    dapm_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (cmd_ch),
        .i_out          (status_ch),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_taken_count  (taken_count),
        .o_missed_count (missed_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost status ends the run as a failure.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $error("run did not complete within %0d cycles", CYCLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // The status receiver picks a stall style when its slot counter wraps: always
    // ready, a random mask, or ready on slots that are multiples of four. The mask
    // keeps a ready bit so a stall never lasts long; always-ready gives no stalls.
    initial begin
        int          slot;
        int          style;
        logic [31:0] mask;
        status_ch.ready = 1'b0;
        slot  = 0;
        style = 0;
        mask  = '1;
        forever begin
            @(negedge i_clk);
            if (slot == 0) begin
                style   = $urandom_range(0, 2);
                mask    = $urandom;
                mask[0] = 1'b1;
                mask[16] = 1'b1;
            end
            case (style)
                0:       status_ch.ready <= 1'b1;
                1:       status_ch.ready <= mask[slot];
                default: status_ch.ready <= (slot % 4 == 0);
            endcase
            slot = (slot + 1) % 32;
        end
    end

    // Presents one tick or command at a falling edge and holds it until the
    // transfer happens. Outside steady phases the sender works in bursts with
    // random gaps between them, so gaps land on every phase of the sequencing.
    // It always returns at a falling edge.
    task automatic send_item(input t_action act, input logic [QTY_BITS-1:0] qa,
                             input logic [QTY_BITS-1:0] qb,
                             input logic [ECHO_W-1:0] echo);
        if (!steady) begin
            if (burst_left == 0) begin
                cmd_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.action  <= act;
        cmd_ch.qty_a   <= qa;
        cmd_ch.qty_b   <= qb;
        cmd_ch.echo_us <= echo;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every predicted status has come back.
    // It always waits for a falling edge so valid is not lowered and raised at once.
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
    endtask

    // Writes the whole register set; only called with the block drained.
    task automatic apply_settings(input t_cfg s);
        write_reg(CFG_OPEN_HOLD, CFG_DATA_W'(s.open_hold_ms));
        write_reg(CFG_SHUT_GAP,  CFG_DATA_W'(s.shut_gap_ms));
        write_reg(CFG_COOLDOWN,  CFG_DATA_W'(s.cooldown_ms));
        write_reg(CFG_CONFIRM,   CFG_DATA_W'(s.confirm_ms));
        write_reg(CFG_TIMEOUT,   CFG_DATA_W'(s.timeout_ms));
        write_reg(CFG_PRESENT,   CFG_DATA_W'(s.present_cm));
        cfg_we <= 1'b0;
        cur = s;
        n_settings++;
    endtask

    // Small timings keep a full dispense and pickup cycle to a few dozen ticks.
    // A zero hold or gap is drawn now and then, since a phase must still last
    // one tick. The threshold is sometimes zero or so high that nothing is present.
    function automatic t_cfg pick_settings();
        t_cfg s;
        s.open_hold_ms = ($urandom_range(0, 7) == 0) ? '0 : HOLD_W'($urandom_range(1, 4));
        s.shut_gap_ms  = ($urandom_range(0, 7) == 0) ? '0 : GAP_W'($urandom_range(1, 4));
        s.cooldown_ms  = COOL_W'($urandom_range(0, 6));
        s.confirm_ms   = CONF_W'($urandom_range(1, 8));
        s.timeout_ms   = TOUT_W'($urandom_range(1, 40));
        case ($urandom_range(0, 5))
            0:       s.present_cm = '0;
            1:       s.present_cm = '1;
            default: s.present_cm = PRES_W'($urandom_range(1, 40));
        endcase
        return s;
    endfunction

    // An echo whose distance is at or below the threshold, so the item reads absent.
    function automatic logic [ECHO_W-1:0] echo_absent(input logic [PRES_W-1:0] p);
        int unsigned top_e;
        top_e = ((int'(p) + 1) * 1000 - 1) / 17;
        if (top_e > 8191) top_e = 8191;
        // With a huge threshold even a missing echo (999 cm) counts as absent.
        if (p >= NO_ECHO_CM && $urandom_range(0, 3) == 0) return '0;
        return ECHO_W'($urandom_range(1, top_e));
    endfunction

    // An echo with distance above a threshold under 999 cm: the item reads present.
    function automatic logic [ECHO_W-1:0] echo_present(input logic [PRES_W-1:0] p);
        int unsigned low_e;
        if (p >= NO_ECHO_CM) return ECHO_W'($urandom);
        low_e = ((int'(p) + 1) * 1000 + 16) / 17;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return (low_e <= 8191) ? '1 : '0;
            default: begin
                if (low_e > 8191) return '0;
                if (low_e > 5000) return ECHO_W'($urandom_range(low_e, 8191));
                return ECHO_W'($urandom_range(low_e, 5000));
            end
        endcase
    endfunction

    // One well-formed dispense: an open with random counts, then enough ticks to
    // pulse every lid and reach a pickup report. The echo leans absent or present
    // per cycle so that both outcomes come up. A few stray commands are mixed in;
    // they are ignored while dispensing and cut the wait short otherwise.
    task automatic run_dispense_cycle();
        logic [QTY_BITS-1:0] qa;
        logic [QTY_BITS-1:0] qb;
        int                  ticks;
        int                  absent_pct;
        int                  hold_t;
        int                  gap_t;
        int                  i;
        case ($urandom_range(0, 9))
            0: begin
                qa = '1;
                qb = QTY_BITS'($urandom);
            end
            1: begin
                qa = '0;
                qb = QTY_BITS'($urandom_range(1, 3));
            end
            default: begin
                qa = QTY_BITS'($urandom_range(0, 3));
                qb = QTY_BITS'($urandom_range(0, 3));
            end
        endcase
        if ($urandom_range(0, 5) == 0) begin
            send_item(t_action'($urandom_range(ACT_CLOSE, ACT_DENY)), QTY_BITS'($urandom),
                      QTY_BITS'($urandom), ECHO_W'($urandom));
        end
        send_item(ACT_OPEN, qa, qb, ECHO_W'($urandom));
        case ($urandom_range(0, 3))
            0:       absent_pct = 0;
            1:       absent_pct = 60;
            2:       absent_pct = 95;
            default: absent_pct = 100;
        endcase
        hold_t = (cur.open_hold_ms == '0) ? 1 : int'(cur.open_hold_ms);
        gap_t  = (cur.shut_gap_ms == '0) ? 1 : int'(cur.shut_gap_ms);
        if (qa == '0 && qb == '0) begin
            ticks = 2;
        end else begin
            ticks = (int'(qa) + int'(qb)) * (hold_t + gap_t) + int'(cur.cooldown_ms)
                    + ((absent_pct >= 95) ? int'(cur.confirm_ms) : int'(cur.timeout_ms))
                    + $urandom_range(1, 4);
        end
        if (ticks > 300) ticks = 300;
        for (i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 39) == 0) begin
                send_item(t_action'($urandom_range(ACT_OPEN, ACT_DENY)), QTY_BITS'($urandom),
                          QTY_BITS'($urandom), ECHO_W'($urandom));
            end else if ($urandom_range(0, 99) < absent_pct) begin
                send_item(ACT_TICK, QTY_BITS'($urandom), QTY_BITS'($urandom),
                          echo_absent(cur.present_cm));
            end else begin
                send_item(ACT_TICK, QTY_BITS'($urandom), QTY_BITS'($urandom),
                          echo_present(cur.present_cm));
            end
        end
    endtask

    initial begin
        t_cfg s;
        int   goal;
        int   phase_start;
        int   pause_at;
        int   n_cycles;
        cmd_ch.valid   = 1'b0;
        cmd_ch.action  = ACT_TICK;
        cmd_ch.qty_a   = '0;
        cmd_ch.qty_b   = '0;
        cmd_ch.echo_us = '0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_OPEN_HOLD;
        cfg_data       = '0;
        i_rst_n        = 1'b0;
        n_sent         = 0;
        n_settings     = 0;
        burst_left     = 0;
        steady         = 1'b0;
        cur = '{RST_OPEN_HOLD, RST_SHUT_GAP, RST_COOLDOWN, RST_CONFIRM, RST_TIMEOUT,
                RST_PRESENT};

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening under the reset settings: an idle tick, an open with
        // nothing to dispense, a deny from idle, a close from locked, another deny,
        // an open from locked, and then commands that must be ignored while busy.
        send_item(ACT_TICK,  '0, '0, '0);
        send_item(ACT_OPEN,  '0, '0, ECHO_W'(5000));
        send_item(ACT_DENY,  '0, '0, '0);
        send_item(ACT_TICK,  '1, '1, '1);
        send_item(ACT_CLOSE, '0, '0, '0);
        send_item(ACT_DENY,  '1, '1, '1);
        send_item(ACT_OPEN,  4'd1, 4'd1, '0);
        send_item(ACT_OPEN,  '1, '1, '1);
        send_item(ACT_CLOSE, '0, '0, '0);
        send_item(ACT_DENY,  '0, '0, '0);
        send_item(ACT_TICK,  '0, '0, '1);

        // Hold and gap at 10000, the rest at their top, while the lid is held open.
        drain();
        s = '{14'd10000, 14'd10000, '1, '1, '1, '1};
        apply_settings(s);
        send_item(ACT_TICK, '0, '0, ECHO_W'(5000));
        send_item(ACT_TICK, '0, '0, '0);

        // Zero hold and gap still take one tick per phase. The other registers, at
        // zero or one, then end the wait at the first sample with a miss.
        drain();
        s = '{'0, '0, '0, 16'd1, 20'd1, '0};
        apply_settings(s);
        repeat (4) send_item(ACT_TICK, '0, '0, '0);
        send_item(ACT_TICK, '0, '0, ECHO_W'(5000));

        // A timeout shorter than the cooldown is only noticed at the first sample,
        // even with the item already gone.
        drain();
        s.cooldown_ms = 16'd3;
        s.timeout_ms  = 20'd2;
        apply_settings(s);
        send_item(ACT_OPEN, '0, 4'd1, '0);
        repeat (5) send_item(ACT_TICK, '0, '0, ECHO_W'(1));

        // Random part: a fresh register setting every phase, every third phase
        // without sender gaps, and once per phase a hold-off until all status
        // transfers have returned.
        goal = n_sent + RANDOM_ITEMS;
        while (n_sent < goal) begin
            drain();
            apply_settings(pick_settings());
            steady      = (n_settings % 3 == 0);
            burst_left  = 0;
            phase_start = n_sent;
            pause_at    = $urandom_range(1, 4);
            n_cycles    = 0;
            while (n_sent - phase_start < PHASE_ITEMS && n_sent < goal) begin
                run_dispense_cycle();
                n_cycles++;
                if (n_cycles == pause_at) drain();
            end
        end

        // Everything has been sent; let the last status transfers come back and
        // leave the clock running so that anything unexpected can show up.
        drain();
        repeat (8) @(negedge i_clk);

        $display("Run covered %0d command and tick transfers over %0d register settings.",
                 n_sent, n_settings);
        $display("Predicted outcomes: %0d pickups confirmed, %0d pickups missed.",
                 taken_count, missed_count);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dapm_pkg.sv
rtl/dapm_in_if.sv
rtl/dapm_out_if.sv
rtl/dapm_cfg.sv
rtl/dapm_dist.sv
rtl/dapm_core.sv
rtl/dispense_and_pickup_monitor.sv
rtl/dapm_checker.sv
verif/dapm_result_checker.sv
verif/tb_top.sv
